@@ rtl/dstk_pkg.sv @@
// shared types and constants for the two-stacks-in-one-array block
`timescale 1ns / 1ps
`default_nettype none

package dstk_pkg;

   // sizes
   localparam int DEPTH_DEFAULT   = 16;
   localparam int WORD_W          = 32;
   localparam int STATUS_W        = 2;
   localparam int REQ_W           = 3;
   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;

   // request codes on the input port
   localparam logic [REQ_W-1:0] REQ_PUSH_ONE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_TWO = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_ONE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_TWO  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LIST_ONE = 3'd4;
   localparam logic [REQ_W-1:0] REQ_LIST_TWO = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // decoded operation
   typedef enum logic [2:0] {
      OP_PUSH_ONE,
      OP_PUSH_TWO,
      OP_POP_ONE,
      OP_POP_TWO,
      OP_LIST_ONE,
      OP_LIST_TWO
   } op_type;

   // command passed from front to back
   typedef struct packed {
      op_type                   op;
      logic signed [WORD_W-1:0] value;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/dual_stack_shared_array_core.sv @@
// top level: two stacks sharing one word memory
// a result passes through the request queue, the result stage and the result queue
// throughput: one push or pop per cycle while the result queue has room; a list
//   reads one word per cycle while there is room and holds back the next request
// reset: stack counts and queues are cleared; memory contents are not
`timescale 1ns / 1ps
`default_nettype none

module dual_stack_shared_array_core
   import dstk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [REQ_W-1:0]           req_type,
   input  wire logic signed [WORD_W-1:0]   req_push_value,
   output logic                            empty,
   input  wire logic                       pop,
   output logic signed [WORD_W-1:0]        rsp_value,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic                            rsp_last
);

   logic                                     cmd_valid;
   cmd_type                                  cmd;
   logic                                     cmd_take;
   logic [$clog2(RSP_QUEUE_DEPTH+1)-1:0]     rsp_level;
   logic                                     rsp_push;
   rsp_type                                  rsp_back;
   rsp_type                                  rsp_head;

   dstk_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   dstk_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp       (rsp_back)
   );

   dstk_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_back),
      .level    (rsp_level),
      .empty    (empty),
      .pop      (pop),
      .rsp_out  (rsp_head)
   );

   // result ports
   assign rsp_value  = rsp_head.value;
   assign rsp_status = rsp_head.status;
   assign rsp_last   = rsp_head.last;

endmodule

`default_nettype wire

@@ rtl/dstk_front.sv @@
// request front end: decodes request codes and queues valid commands
`timescale 1ns / 1ps
`default_nettype none

module dstk_front
   import dstk_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   output logic                          full,
   input  wire logic [REQ_W-1:0]         req_type,
   input  wire logic signed [WORD_W-1:0] req_push_value,
   output logic                          cmd_valid,
   output cmd_type                       cmd,
   input  wire logic                     cmd_take
);

   localparam int PW = $clog2(REQ_QUEUE_DEPTH);
   localparam int LW = $clog2(REQ_QUEUE_DEPTH + 1);

   cmd_type          queue_ff [REQ_QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             code_ok;
   logic             store;
   cmd_type          decoded;

   // decode the request code; unused codes are dropped
   always_comb begin
      code_ok       = 1'b1;
      decoded.value = req_push_value;
      decoded.op    = OP_PUSH_ONE;
      unique case (req_type)
         REQ_PUSH_ONE: decoded.op = OP_PUSH_ONE;
         REQ_PUSH_TWO: decoded.op = OP_PUSH_TWO;
         REQ_POP_ONE:  decoded.op = OP_POP_ONE;
         REQ_POP_TWO:  decoded.op = OP_POP_TWO;
         REQ_LIST_ONE: decoded.op = OP_LIST_ONE;
         REQ_LIST_TWO: decoded.op = OP_LIST_TWO;
         default:      code_ok    = 1'b0;
      endcase
   end

   // queue pointers and fill level
   always_comb begin
      full      = (level_ff == LW'(REQ_QUEUE_DEPTH));
      cmd_valid = (level_ff != '0);
      cmd       = queue_ff[rd_ptr_ff];
      store     = push && !full && code_ok;
      wr_ptr_in = store ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + LW'(store) - LW'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (store) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dstk_back.sv @@
// execution back end: shared memory, stack counts and list sequencer
`timescale 1ns / 1ps
`default_nettype none

module dstk_back
   import dstk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  cmd_valid,
   input  wire cmd_type                               cmd,
   output logic                                       cmd_take,
   input  wire logic [$clog2(RSP_QUEUE_DEPTH+1)-1:0]  rsp_level,
   output logic                                       rsp_push,
   output rsp_type                                    rsp
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int RLW = $clog2(RSP_QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
   localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

   typedef enum logic {S_IDLE, S_LIST} state_type;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_low_ff, count_low_in;
   logic [CW-1:0]       count_high_ff, count_high_in;
   logic [AW-1:0]       list_addr_ff, list_addr_in;
   logic [AW-1:0]       list_end_ff, list_end_in;
   logic                list_up_ff, list_up_in;
   logic                s1_valid_ff, s1_last_ff, s1_read_ff;
   logic [STATUS_W-1:0] s1_status_ff;

   logic [RLW:0]        used;
   logic                can_issue;
   logic                issue;
   logic                iss_read;
   logic                iss_last;
   logic [STATUS_W-1:0] iss_status;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic                stacks_full;
   logic [CW-1:0]       low_dec;
   logic [CW-1:0]       high_base;

   // room check: queue level plus the result still in flight
   always_comb begin
      used      = {1'b0, rsp_level} + (RLW + 1)'(s1_valid_ff);
      can_issue = (used < (RLW + 1)'(RSP_QUEUE_DEPTH));
   end

   // command decode and list stepping
   always_comb begin
      stacks_full   = ({1'b0, count_low_ff} + {1'b0, count_high_ff}) >= {1'b0, DEPTH_C};
      low_dec       = count_low_ff - 1'b1;
      high_base     = DEPTH_C - count_high_ff;
      cmd_take      = 1'b0;
      issue         = 1'b0;
      iss_read      = 1'b0;
      iss_last      = 1'b1;
      iss_status    = ST_OK;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      state_in      = state_ff;
      count_low_in  = count_low_ff;
      count_high_in = count_high_ff;
      list_addr_in  = list_addr_ff;
      list_end_in   = list_end_ff;
      list_up_in    = list_up_ff;
      priority if (state_ff == S_LIST) begin
         if (can_issue) begin
            issue    = 1'b1;
            iss_read = 1'b1;
            rd_addr  = list_addr_ff;
            iss_last = (list_addr_ff == list_end_ff);
            if (iss_last) begin
               state_in = S_IDLE;
            end else begin
               list_addr_in = list_up_ff ? list_addr_ff + 1'b1 : list_addr_ff - 1'b1;
            end
         end
      end else if (cmd_valid && can_issue) begin
         cmd_take = 1'b1;
         issue    = 1'b1;
         unique case (cmd.op)
            OP_PUSH_ONE: begin
               if (stacks_full) begin
                  iss_status = ST_OVERFLOW;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = count_low_ff[AW-1:0];
                  count_low_in = count_low_ff + 1'b1;
               end
            end
            OP_PUSH_TWO: begin
               if (stacks_full) begin
                  iss_status = ST_OVERFLOW;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = TOP_ADDR - count_high_ff[AW-1:0];
                  count_high_in = count_high_ff + 1'b1;
               end
            end
            OP_POP_ONE: begin
               if (count_low_ff == '0) begin
                  iss_status = ST_UNDERFLOW;
               end else begin
                  iss_read     = 1'b1;
                  rd_addr      = low_dec[AW-1:0];
                  count_low_in = low_dec;
               end
            end
            OP_POP_TWO: begin
               if (count_high_ff == '0) begin
                  iss_status = ST_UNDERFLOW;
               end else begin
                  iss_read      = 1'b1;
                  rd_addr       = high_base[AW-1:0];
                  count_high_in = count_high_ff - 1'b1;
               end
            end
            OP_LIST_ONE: begin
               if (count_low_ff == '0) begin
                  iss_status = ST_EMPTY;
               end else begin
                  iss_read = 1'b1;
                  rd_addr  = low_dec[AW-1:0];
                  iss_last = (low_dec[AW-1:0] == '0);
                  if (!iss_last) begin
                     state_in     = S_LIST;
                     list_addr_in = low_dec[AW-1:0] - 1'b1;
                     list_end_in  = '0;
                     list_up_in   = 1'b0;
                  end
               end
            end
            OP_LIST_TWO: begin
               if (count_high_ff == '0) begin
                  iss_status = ST_EMPTY;
               end else begin
                  iss_read = 1'b1;
                  rd_addr  = high_base[AW-1:0];
                  iss_last = (high_base[AW-1:0] == TOP_ADDR);
                  if (!iss_last) begin
                     state_in     = S_LIST;
                     list_addr_in = high_base[AW-1:0] + 1'b1;
                     list_end_in  = TOP_ADDR;
                     list_up_in   = 1'b1;
                  end
               end
            end
            default: begin
               issue = 1'b0;
            end
         endcase
      end
   end

   // sequencer state, counts and result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_low_ff  <= '0;
         count_high_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
         s1_valid_ff   <= issue;
      end
      list_addr_ff <= list_addr_in;
      list_end_ff  <= list_end_in;
      list_up_ff   <= list_up_in;
      s1_last_ff   <= iss_last;
      s1_read_ff   <= iss_read;
      s1_status_ff <= iss_status;
   end

   // shared word memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.value;
      end
      if (iss_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result toward the output queue
   always_comb begin
      rsp_push   = s1_valid_ff;
      rsp.value  = s1_read_ff ? rd_data_ff : '0;
      rsp.status = s1_status_ff;
      rsp.last   = s1_last_ff;
   end

endmodule

`default_nettype wire

@@ rtl/dstk_rsp_queue.sv @@
// result queue between the back end and the result ports
`timescale 1ns / 1ps
`default_nettype none

module dstk_rsp_queue
   import dstk_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 rsp_push,
   input  wire rsp_type                              rsp_in,
   output logic [$clog2(RSP_QUEUE_DEPTH+1)-1:0]      level,
   output logic                                      empty,
   input  wire logic                                 pop,
   output rsp_type                                   rsp_out
);

   localparam int PW = $clog2(RSP_QUEUE_DEPTH);
   localparam int LW = $clog2(RSP_QUEUE_DEPTH + 1);

   rsp_type       queue_ff [RSP_QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;
   logic          take;

   // pointers and level; the back end never pushes into a full queue
   always_comb begin
      level     = level_ff;
      empty     = (level_ff == '0);
      rsp_out   = queue_ff[rd_ptr_ff];
      take      = pop && !empty;
      wr_ptr_in = rsp_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + LW'(rsp_push) - LW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         queue_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// testbench for the two-stacks-in-one-array block: directed and random requests
`timescale 1ns / 1ps

module tb;
   import dstk_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // request codes that the block ignores
   localparam logic [REQ_W-1:0] REQ_SPARE_SIX   = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_SEVEN = 3'd7;
   // cycles without any transfer before the run is declared hung
   localparam int HANG_LIMIT = 3000;
   // random mix modes
   localparam int MIX_FILL     = 0;
   localparam int MIX_DRAIN    = 1;
   localparam int MIX_LOW_FILL = 2;

   logic clock = 1'b0;
   logic reset;
   logic push;
   logic full;
   logic [REQ_W-1:0] req_type;
   logic signed [WORD_W-1:0] req_push_value;
   logic empty;
   logic pop;
   logic signed [WORD_W-1:0] rsp_value;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_last;

   // shadow copy of the stacks
   logic signed [WORD_W-1:0] stack_words [DEPTH];
   int low_count;
   int high_count;

   rsp_type pending_rsp [$];
   int mismatches;
   int quiet_cycles;
   bit idle_on;
   int stall_left;

   dual_stack_shared_array_core #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_push_value(req_push_value),
      .empty(empty),
      .pop(pop),
      .rsp_value(rsp_value),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // expected results of one accepted request, shadow stacks updated
   task automatic predict_stack_op(input logic [REQ_W-1:0] kind,
                                   input logic signed [WORD_W-1:0] word);
      rsp_type r;
      bit meet;
      meet = (low_count + high_count) >= DEPTH;
      r.value = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      case (kind)
         REQ_PUSH_ONE: begin
            if (meet) begin
               r.status = ST_OVERFLOW;
            end else begin
               stack_words[low_count] = word;
               low_count++;
            end
            pending_rsp.push_back(r);
         end
         REQ_PUSH_TWO: begin
            if (meet) begin
               r.status = ST_OVERFLOW;
            end else begin
               high_count++;
               stack_words[DEPTH - high_count] = word;
            end
            pending_rsp.push_back(r);
         end
         REQ_POP_ONE: begin
            if (low_count == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               low_count--;
               r.value = stack_words[low_count];
            end
            pending_rsp.push_back(r);
         end
         REQ_POP_TWO: begin
            if (high_count == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               r.value = stack_words[DEPTH - high_count];
               high_count--;
            end
            pending_rsp.push_back(r);
         end
         REQ_LIST_ONE: begin
            if (low_count == 0) begin
               r.status = ST_EMPTY;
               pending_rsp.push_back(r);
            end else begin
               for (int i = low_count - 1; i >= 0; i--) begin
                  r.value = stack_words[i];
                  r.last = (i == 0);
                  pending_rsp.push_back(r);
               end
            end
         end
         REQ_LIST_TWO: begin
            if (high_count == 0) begin
               r.status = ST_EMPTY;
               pending_rsp.push_back(r);
            end else begin
               for (int i = DEPTH - high_count; i < DEPTH; i++) begin
                  r.value = stack_words[i];
                  r.last = (i == DEPTH - 1);
                  pending_rsp.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // send one request, with an optional idle burst before it
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic signed [WORD_W-1:0] word);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         push = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push = 1'b1;
      req_type = kind;
      req_push_value = word;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_stack_op(kind, word);
   endtask

   // stop sending and wait until every expected result has come
   task automatic wait_for_results();
      @(negedge clock);
      push = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // push data biased toward the extremes, every bit still random
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] pick_req(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == MIX_FILL) begin
         if (r < 35) return REQ_PUSH_ONE;
         if (r < 70) return REQ_PUSH_TWO;
         if (r < 78) return REQ_POP_ONE;
         if (r < 86) return REQ_POP_TWO;
         if (r < 92) return REQ_LIST_ONE;
         if (r < 97) return REQ_LIST_TWO;
      end else if (mode == MIX_DRAIN) begin
         if (r < 10) return REQ_PUSH_ONE;
         if (r < 20) return REQ_PUSH_TWO;
         if (r < 55) return REQ_POP_ONE;
         if (r < 88) return REQ_POP_TWO;
         if (r < 93) return REQ_LIST_ONE;
         if (r < 98) return REQ_LIST_TWO;
      end else begin
         if (r < 70) return REQ_PUSH_ONE;
         if (r < 75) return REQ_PUSH_TWO;
         if (r < 80) return REQ_POP_ONE;
         if (r < 88) return REQ_POP_TWO;
         if (r < 95) return REQ_LIST_ONE;
         if (r < 98) return REQ_LIST_TWO;
      end
      return (r[0]) ? REQ_SPARE_SEVEN : REQ_SPARE_SIX;
   endfunction

   // pops, lists of empty stacks right after reset
   task automatic test_empty_stacks();
      send_request(REQ_POP_ONE, 32'sh1234_5678);
      send_request(REQ_POP_TWO, -32'sd1);
      send_request(REQ_LIST_ONE, '0);
      send_request(REQ_LIST_TWO, 32'sh8000_0000);
   endtask

   // extreme words on both stacks, read back by list and pop
   task automatic test_edge_values();
      send_request(REQ_PUSH_ONE, 32'sh7fff_ffff);
      send_request(REQ_PUSH_ONE, 32'sh8000_0000);
      send_request(REQ_PUSH_TWO, -32'sd1);
      send_request(REQ_PUSH_TWO, '0);
      send_request(REQ_LIST_ONE, '0);
      send_request(REQ_LIST_TWO, '0);
      send_request(REQ_POP_ONE, '0);
      send_request(REQ_POP_TWO, '0);
   endtask

   // unused codes must give no result and leave the stacks alone
   task automatic test_unused_codes();
      send_request(REQ_SPARE_SIX, -32'sd1);
      send_request(REQ_SPARE_SEVEN, 32'sh5555_aaaa);
      wait_for_results();
   endtask

   // fill until the stacks meet, overflow both sides, list full stacks
   task automatic test_stacks_meet();
      while (low_count + high_count < DEPTH)
         send_request((low_count < 9) ? REQ_PUSH_ONE : REQ_PUSH_TWO, pick_word());
      send_request(REQ_PUSH_ONE, 32'sh0bad_0001);
      send_request(REQ_PUSH_TWO, 32'sh0bad_0002);
      send_request(REQ_LIST_ONE, '0);
      send_request(REQ_LIST_TWO, '0);
   endtask

   // random segments that cycle through draining, filling and low-side filling mixes
   task automatic test_random_mix();
      int mode;
      for (int seg = 0; seg < 6; seg++) begin
         case (seg % 3)
            0: mode = MIX_DRAIN;
            1: mode = MIX_FILL;
            default: mode = MIX_LOW_FILL;
         endcase
         for (int n = 0; n < 42; n++)
            send_request(pick_req(mode), pick_word());
         // let the result side catch up once mid-run
         if (seg == 2) wait_for_results();
      end
   endtask

   // last part: no idling on either side
   task automatic test_back_to_back();
      idle_on = 1'b0;
      for (int n = 0; n < 30; n++)
         send_request(pick_req(n < 15 ? MIX_FILL : MIX_DRAIN), pick_word());
   endtask

   // result side: random stall bursts while idling is on
   always @(negedge clock) begin
      if (idle_on && stall_left > 0) begin
         stall_left--;
         pop = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         pop = 1'b0;
      end else begin
         pop = 1'b1;
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value=%0d status=%0d last=%0b",
                        rsp_value, rsp_status, rsp_last);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_value !== want.value || rsp_status !== want.status ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch: expected value=%0d status=%0d last=%0b,",
                         want.value, want.status, want.last);
                  $display(" got value=%0d status=%0d last=%0b",
                           rsp_value, rsp_status, rsp_last);
               end
            end
         end
      end
   end

   // hang watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_type = REQ_PUSH_ONE;
      req_push_value = '0;
      low_count = 0;
      high_count = 0;
      mismatches = 0;
      quiet_cycles = 0;
      stall_left = 0;
      idle_on = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_stacks();
      test_edge_values();
      test_unused_codes();
      test_stacks_meet();
      test_random_mix();
      test_back_to_back();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (pending_rsp.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
